[rtl/actr_pkg.sv]
// actr_pkg: shared types, constants and functions for the aes-128 ctr stream engine
// no dependencies
`timescale 1ns / 1ps
package actr_pkg;

   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrDataWidth = 64;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_KEY_HIGH   = 3'd0,
      CSR_KEY_LOW    = 3'd1,
      CSR_CTR_HIGH   = 3'd2,
      CSR_CTR_LOW    = 3'd3,
      CSR_LITTLE_END = 3'd4
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_XOR,
      ST_OUT
   } state_type;

   // per-round control from the top-level sequencer to the round unit
   typedef struct packed {
      logic       load;
      logic       step;
      logic [3:0] round;
   } round_ctl_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // state byte i sits at bits [127-8i -: 8]
   function automatic logic [7:0] get_byte(input logic [127:0] w, input logic [3:0] i);
      return w[8'd127 - {i, 3'b000} -: 8];
   endfunction

endpackage

[rtl/actr_if.sv]
// actr_if: valid/ready stream channels, a request with a data byte and a message_end flag, a response with a data byte
// depends on nothing
`timescale 1ns / 1ps
interface actr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_in;
   logic       message_end;
   modport source (output valid, output data_in, output message_end, input ready);
   modport sink (input valid, input data_in, input message_end, output ready);
endinterface

interface actr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_out;
   modport source (output valid, output data_out, input ready);
   modport sink (input valid, input data_out, output ready);
endinterface

[rtl/aes128_ctr_stream.sv]
// aes128_ctr_stream: aes-128 counter-mode keystream engine, one byte per request
// depends on actr_pkg, actr_if, actr_round
`timescale 1ns / 1ps
// Usage:
//  req channel carries one data byte and a message_end flag; rsp returns the
//  byte xored with the keystream byte of the current counter block.
//  csr port: write enable, index (0 key_high, 1 key_low, 2 counter high,
//  3 counter low, 4 little_endian_count) and 64-bit data. Any write to index 0-4
//  restarts the message; the user must write only while the block is idle, the block itself does not enforce it.
//  Sequence: a request that needs a fresh keystream block loads the round
//  unit, runs ten rounds of the shared round unit, then the xor state and
//  the output state; other requests go through the xor and output states
//  only. The next request is taken the cycle after the response is taken.
//  Round keys are computed on the fly alongside each round.
//  One request is in flight at a time; req_ready is low until the response
//  is taken. When the receiver stalls, rsp_valid and data stay put.
//  Reset: synchronous, active high; control, key and counter registers clear
//  to zero and the keystream is marked stale; payload registers are not reset.
module aes128_ctr_stream (
   input  logic             clock,
   input  logic             reset,
   actr_req_if.sink         req,
   actr_rsp_if.source       rsp,
   input  logic             csr_write,
   input  logic [actr_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [actr_pkg::CsrDataWidth-1:0] csr_data
);
   import actr_pkg::*;

   state_type     state_ff, state_in;
   logic [127:0]  key_ff, start_ff, ctr_ff;
   logic          le_ff, ks_valid_ff;
   logic [3:0]    pos_ff, round_ff;
   logic [7:0]    data_ff, out_ff;
   logic          end_ff;
   logic [127:0]  ctr_inc;
   logic [127:0]  aes_out;
   round_ctl_type ctl;
   logic          accept;

   assign accept = req.valid && req.ready;

   actr_round u_round (
      .clock  (clock),
      .ctl    (ctl),
      .key    (key_ff),
      .block  (ctr_ff),
      .result (aes_out)
   );

   // counter increment with byte order selected
   always_comb begin
      logic carry;
      logic [7:0] b;
      logic [3:0] idx;
      ctr_inc = ctr_ff;
      carry = 1'b1;
      for (int i = 0; i < 16; i++) begin
         idx = le_ff ? 4'(i) : 4'(15 - i);
         b = get_byte(ctr_ff, idx) + {7'd0, carry};
         ctr_inc[127 - 8*idx -: 8] = b;
         carry = carry && (b == 8'h00);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = ks_valid_ff ? ST_XOR : ST_ROUND;
         ST_ROUND: if (round_ff == 4'd10) state_in = ST_XOR;
         ST_XOR:   state_in = ST_OUT;
         ST_OUT:   if (rsp.ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl.load  = accept && !ks_valid_ff;
      ctl.step  = (state_ff == ST_ROUND);
      ctl.round = round_ff;
      req.ready = (state_ff == ST_IDLE);
      rsp.valid = (state_ff == ST_OUT);
      rsp.data_out = out_ff;
   end

   // control and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         key_ff      <= '0;
         start_ff    <= '0;
         ctr_ff      <= '0;
         le_ff       <= 1'b0;
         ks_valid_ff <= 1'b0;
         pos_ff      <= '0;
         round_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_KEY_HIGH:   key_ff[127:64] <= csr_data;
               CSR_KEY_LOW:    key_ff[63:0] <= csr_data;
               CSR_CTR_HIGH:   start_ff[127:64] <= csr_data;
               CSR_CTR_LOW:    start_ff[63:0] <= csr_data;
               CSR_LITTLE_END: le_ff <= csr_data[0];
               default: ;
            endcase
            if (csr_index <= CSR_LITTLE_END) begin
               ctr_ff      <= (csr_index == CSR_CTR_HIGH) ? {csr_data, start_ff[63:0]} :
                              (csr_index == CSR_CTR_LOW) ? {start_ff[127:64], csr_data} :
                              start_ff;
               pos_ff      <= '0;
               ks_valid_ff <= 1'b0;
            end
         end
         if (accept) round_ff <= 4'd1;
         else if (ctl.step) round_ff <= round_ff + 4'd1;
         if (state_ff == ST_ROUND && round_ff == 4'd10) ks_valid_ff <= 1'b1;
         // advance position once the keystream byte is used; restart the counter at message end
         if (state_ff == ST_XOR) begin
            if (end_ff) begin
               ctr_ff      <= start_ff;
               pos_ff      <= '0;
               ks_valid_ff <= 1'b0;
            end else if (pos_ff == 4'd15) begin
               ctr_ff      <= ctr_inc;
               pos_ff      <= '0;
               ks_valid_ff <= 1'b0;
            end else begin
               pos_ff <= pos_ff + 4'd1;
            end
         end
      end
   end

   // payload registers; the round unit holds the keystream until its next load
   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req.data_in;
         end_ff  <= req.message_end;
      end
      if (state_ff == ST_XOR) out_ff <= data_ff ^ get_byte(aes_out, pos_ff);
   end

   // checks
   a_no_ready_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready) else $error("ready while busy");
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (round_ff >= 4'd1 && round_ff <= 4'd10))
      else $error("round out of range");
   a_xor_has_ks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_XOR) |-> ks_valid_ff) else $error("xor without keystream");
   a_out_follows_xor: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(state_ff == ST_XOR)) else $error("bad output entry");
endmodule

[rtl/actr_round.sv]
// actr_round: one aes-128 round per cycle while step is set, with the on-the-fly key schedule
// depends on actr_pkg
`timescale 1ns / 1ps
module actr_round (
   input  logic                   clock,
   input  actr_pkg::round_ctl_type ctl,
   input  logic [127:0]           key,
   input  logic [127:0]           block,
   output logic [127:0]           result
);
   import actr_pkg::*;

   logic [127:0] state_ff, state_in;
   logic [127:0] rkey_ff, rkey_in;
   logic [127:0] sub, mix;
   logic [31:0]  w3, tw;
   logic [7:0]   rc;

   // next round key from the current one
   always_comb begin
      w3 = rkey_ff[31:0];
      case (ctl.round)
         4'd1: rc = 8'h01;
         4'd2: rc = 8'h02;
         4'd3: rc = 8'h04;
         4'd4: rc = 8'h08;
         4'd5: rc = 8'h10;
         4'd6: rc = 8'h20;
         4'd7: rc = 8'h40;
         4'd8: rc = 8'h80;
         4'd9: rc = 8'h1b;
         default: rc = 8'h36;
      endcase
      tw = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      rkey_in[127:96] = rkey_ff[127:96] ^ tw;
      rkey_in[95:64]  = rkey_ff[95:64] ^ rkey_in[127:96];
      rkey_in[63:32]  = rkey_ff[63:32] ^ rkey_in[95:64];
      rkey_in[31:0]   = rkey_ff[31:0] ^ rkey_in[63:32];
   end

   // sub bytes and shift rows, then mix columns (skipped in round 10) and add the round key
   always_comb begin
      logic [7:0] a0, a1, a2, a3, al;
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            sub[127 - 8*(i + 4*c) -: 8] =
               sbox(state_ff[127 - 8*(i + 4*((c + i) % 4)) -: 8]);
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = sub[127 - 32*c -: 8];
         a1 = sub[119 - 32*c -: 8];
         a2 = sub[111 - 32*c -: 8];
         a3 = sub[103 - 32*c -: 8];
         al = a0 ^ a1 ^ a2 ^ a3;
         mix[127 - 32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
         mix[119 - 32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
         mix[111 - 32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
         mix[103 - 32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
      end
      state_in = ((ctl.round == 4'd10) ? sub : mix) ^ rkey_in;
   end

   // round state and key registers
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         state_ff <= block ^ key;
         rkey_ff  <= key;
      end else if (ctl.step) begin
         state_ff <= state_in;
         rkey_ff  <= rkey_in;
      end
   end

   assign result = state_ff;
endmodule
